### design/edws_pkg.sv
`default_nettype none

package edws_pkg;

    // Vector length actually summed, and number of Wilkes steps.
    localparam int DIMENSION  = 4;
    localparam int ITERATIONS = 6;

    // Element slots on the input bus, regardless of DIMENSION.
    localparam int VEC_SLOTS  = 4;
    localparam int ELEM_W     = 16;
    localparam int SQD_W      = 33;
    localparam int DIST_W     = 16;
    localparam int FRAC_BITS  = 28;

    localparam logic [SQD_W-1:0] SQD_MAX   = {SQD_W{1'b1}};
    localparam logic [33:0]      LIMIT_Q30 = 34'd3 << 30;

    localparam logic signed [33:0] ONE_Q28   = 34'sd1 << FRAC_BITS;
    localparam logic signed [33:0] THREE_Q28 = 34'sd3 << FRAC_BITS;

    localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
    localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

    // Payload carried between the Wilkes stages.
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [SQD_W-1:0]   sq_dist;
        logic               flag;
    } edws_data_t;

    // Clamp a product already shifted down by FRAC_BITS to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/edws_iter.sv
`default_nettype none

// One Wilkes step over two register stages. The first stage forms
// a*(1 - b/2), b*b and (b - 3)/4; the second multiplies the square by the quarter.
module edws_iter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire edws_pkg::edws_data_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output edws_pkg::edws_data_t     out_data
);
    import edws_pkg::*;

    logic               va_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] sq_reg;
    logic signed [31:0] qt_reg;
    logic [SQD_W-1:0]   sqd_a_reg;
    logic               flag_a_reg;

    logic               vb_reg;
    edws_data_t         data_b_reg;

    logic               ready_a;
    logic               ready_b;

    logic signed [33:0] b_ext;
    logic signed [33:0] factor_w;
    logic signed [33:0] quarter_w;
    logic signed [31:0] factor;
    logic signed [31:0] quarter;
    logic signed [63:0] prod_a;
    logic signed [63:0] prod_s;
    logic signed [63:0] prod_b;
    logic signed [31:0] a1_next;
    logic signed [31:0] sq_next;
    logic signed [31:0] b_next;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb begin
        b_ext     = {{2{in_data.b[31]}}, in_data.b};
        factor_w  = ONE_Q28 - (b_ext >>> 1);
        quarter_w = (b_ext - THREE_Q28) >>> 2;
        factor    = factor_w[31:0];
        quarter   = quarter_w[31:0];
        prod_a    = in_data.a * factor;
        prod_s    = in_data.b * in_data.b;
        a1_next   = sat32($signed(prod_a[63:28]));
        sq_next   = sat32($signed(prod_s[63:28]));
        prod_b    = sq_reg * qt_reg;
        b_next    = sat32($signed(prod_b[63:28]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                va_reg <= in_valid;
            end
            if (ready_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            a1_reg     <= a1_next;
            sq_reg     <= sq_next;
            qt_reg     <= quarter;
            sqd_a_reg  <= in_data.sq_dist;
            flag_a_reg <= in_data.flag;
        end
        if (ready_b && va_reg) begin
            data_b_reg.a       <= a1_reg;
            data_b_reg.b       <= b_next;
            data_b_reg.sq_dist <= sqd_a_reg;
            data_b_reg.flag    <= flag_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = data_b_reg;

endmodule

`default_nettype wire

### design/euclidean_distance_wilkes_sqrt_unit.sv
`default_nettype none
// Each Wilkes step is a pair of 32x32 multiplier stages. From input transaction to result:
// one stage of element squares, one of summing, two per Wilkes step, one output register.
// Throughput: one transaction per cycle, as long as the result side does not stall.
// Each stage stalls only when it holds data its successor cannot take, so bubbles collapse.
// Reset: aresetn is synchronous, active low, and clears every valid bit; no data is held.

module euclidean_distance_wilkes_sqrt_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0 up: x_0, x_1, x_2, x_3, y_0, y_1, y_2, y_3 (16 bits each).
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0 up: squared_distance (33), distance (16), zero fill (7).
    output logic [55:0]       m_tdata,
    // Fields from bit 0 up: out_of_range.
    output logic [0:0]        m_tuser
);
    import edws_pkg::*;

    // Stage 0: element squares.
    logic                    v0_reg;
    logic [31:0]             sqr_reg [DIMENSION];
    logic [31:0]             sqr_next [DIMENSION];
    logic                    ready0;

    // Stage 1: sum, range check and start values.
    logic                    v1_reg;
    edws_data_t              d1_reg;
    edws_data_t              d1_next;
    logic                    ready1;
    logic [33:0]             sum;

    // Wilkes chain.
    logic                    it_valid [ITERATIONS+1];
    logic                    it_ready [ITERATIONS+1];
    edws_data_t              it_data  [ITERATIONS+1];

    // Output register.
    logic                    vo_reg;
    logic [SQD_W-1:0]        sqd_o_reg;
    logic [DIST_W-1:0]       dist_o_reg;
    logic                    flag_o_reg;
    logic [DIST_W-1:0]       dist_next;
    logic signed [31:0]      r_shift;
    logic                    ready_o;

    assign ready_o  = !vo_reg || m_tready;
    assign ready1   = !v1_reg || it_ready[0];
    assign ready0   = !v0_reg || ready1;
    assign s_tready = ready0;

    always_comb begin
        for (int i = 0; i < DIMENSION; i++) begin
            logic signed [16:0] d;
            logic signed [33:0] p;
            d = $signed({1'b0, s_tdata[ELEM_W*i +: ELEM_W]})
                - $signed({1'b0, s_tdata[ELEM_W*(VEC_SLOTS+i) +: ELEM_W]});
            p = d * d;
            sqr_next[i] = p[31:0];
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < DIMENSION; i++) begin
            sum = sum + 34'(sqr_reg[i]);
        end
        d1_next.flag    = (sum >= LIMIT_Q30);
        d1_next.sq_dist = (sum > 34'(SQD_MAX)) ? SQD_MAX : sum[SQD_W-1:0];
        // Below the limit the sum fits in 32 bits, so s = sum >> 2 is non-negative.
        d1_next.a       = $signed({2'b00, sum[31:2]});
        d1_next.b       = $signed({2'b00, sum[31:2]}) - 32'sd268435456;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ready0) begin
                v0_reg <= s_tvalid;
            end
            if (ready1) begin
                v1_reg <= v0_reg;
            end
            if (ready_o) begin
                vo_reg <= it_valid[ITERATIONS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready0 && s_tvalid) begin
            sqr_reg <= sqr_next;
        end
        if (ready1 && v0_reg) begin
            d1_reg <= d1_next;
        end
        if (ready_o && it_valid[ITERATIONS]) begin
            sqd_o_reg  <= it_data[ITERATIONS].sq_dist;
            dist_o_reg <= dist_next;
            flag_o_reg <= it_data[ITERATIONS].flag;
        end
    end

    assign it_valid[0] = v1_reg;
    assign it_data[0]  = d1_reg;
    assign it_ready[ITERATIONS] = ready_o;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        edws_iter u_iter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (it_valid[g]),
            .in_ready  (it_ready[g]),
            .in_data   (it_data[g]),
            .out_valid (it_valid[g+1]),
            .out_ready (it_ready[g+1]),
            .out_data  (it_data[g+1])
        );
    end

    always_comb begin
        r_shift = it_data[ITERATIONS].a >>> (FRAC_BITS - 15);
        if (it_data[ITERATIONS].flag) begin
            dist_next = {DIST_W{1'b1}};
        end else if (r_shift < 0) begin
            dist_next = '0;
        end else if (r_shift > 32'sd65535) begin
            dist_next = {DIST_W{1'b1}};
        end else begin
            dist_next = r_shift[DIST_W-1:0];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {7'd0, dist_o_reg, sqd_o_reg};
    assign m_tuser  = flag_o_reg;

    a_flag_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[48:33] == 16'hFFFF)
        else $error("flagged result without saturated distance");

    a_flag_matches_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] == (34'(m_tdata[32:0]) >= LIMIT_Q30))
        else $error("range flag disagrees with squared distance");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !v0_reg && !v1_reg)
        else $error("pipeline holds data after reset");

    a_bubble_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !v0_reg && !v1_reg && !it_valid[0] |-> s_tready)
        else $error("input stalled while the front stages are empty");

endmodule

`default_nettype wire

### test/distance_checker.sv
module distance_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [55:0]  m_tdata,
    input  wire logic [0:0]   m_tuser,
    output int                mismatch_count,
    output int                pending_count,
    output int                result_count,
    output int                flagged_count,
    output int                clipped_count
);

    localparam int VEC_LEN      = 4;
    localparam int WILKES_STEPS = 6;
    localparam int Q_FRAC       = 28;
    localparam int OUT_SHIFT    = Q_FRAC - 15;
    localparam int PRINT_LIMIT  = 40;

    localparam longint          Q_ONE       = longint'(1) <<< Q_FRAC;
    localparam longint          Q_THREE     = longint'(3) <<< Q_FRAC;
    localparam longint unsigned DIVERGE_SUM = longint'(3) << 30;
    localparam longint unsigned SUM_CEILING = (longint'(1) << 33) - 1;
    localparam longint          WORD_MAX    = 64'sd2147483647;
    localparam longint          WORD_MIN    = -64'sd2147483648;

    typedef struct {
        logic [32:0] sq_dist;
        logic [15:0] distance;
        logic        diverged;
    } dist_result_t;

    dist_result_t expected_results[$];

    int mismatches = 0;
    int pending    = 0;
    int results    = 0;
    int flagged    = 0;
    int clipped    = 0;

    assign mismatch_count = mismatches;
    assign pending_count  = pending;
    assign result_count   = results;
    assign flagged_count  = flagged;
    assign clipped_count  = clipped;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // Signed Q3.28 product; the arithmetic shift rounds toward minus infinity.
    function automatic longint q28_product(input longint p, input longint q);
        return clamp_word((p * q) >>> Q_FRAC);
    endfunction

    function automatic dist_result_t wilkes_distance(input logic [127:0] word);
        dist_result_t    r;
        longint unsigned total;
        longint          diff;
        longint          a;
        longint          b;
        longint          factor;
        longint          quarter;
        longint          b_sq;
        longint          root;
        int              i;
        total = 0;
        for (i = 0; i < VEC_LEN; i++) begin
            diff = longint'(word[16*i +: 16]) - longint'(word[64 + 16*i +: 16]);
            total += longint'(diff * diff);
        end
        r.sq_dist  = (total > SUM_CEILING) ? SUM_CEILING[32:0] : total[32:0];
        r.diverged = (total >= DIVERGE_SUM);
        if (r.diverged) begin
            r.distance = 16'hFFFF;
        end else begin
            a = longint'(total >> 2);
            b = a - Q_ONE;
            for (i = 0; i < WILKES_STEPS; i++) begin
                factor  = clamp_word(Q_ONE - (b >>> 1));
                quarter = clamp_word((b - Q_THREE) >>> 2);
                b_sq    = q28_product(b, b);
                a       = q28_product(a, factor);
                b       = q28_product(b_sq, quarter);
            end
            root = a >>> OUT_SHIFT;
            if (root < 0) begin
                root = 0;
            end
            if (root > 65535) begin
                root = 65535;
            end
            r.distance = root[15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("%0t checker: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    always @(posedge aclk) begin
        dist_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(), wilkes_distance(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected",
                                    {m_tuser, m_tdata}, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (want.diverged) begin
                        flagged++;
                    end
                    if (want.sq_dist == SUM_CEILING[32:0]) begin
                        clipped++;
                    end
                    if (m_tdata[32:0] !== want.sq_dist) begin
                        report_mismatch("squared_distance", m_tdata[32:0], want.sq_dist);
                    end
                    if (m_tdata[48:33] !== want.distance) begin
                        report_mismatch("distance", m_tdata[48:33], want.distance);
                    end
                    if (m_tdata[55:49] !== 7'd0) begin
                        report_mismatch("zero fill of m_tdata", m_tdata[55:49], 0);
                    end
                    if (m_tuser[0] !== want.diverged) begin
                        report_mismatch("out_of_range", m_tuser[0], want.diverged);
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

### test/tb_top.sv
module tb_top;

    localparam int RANDOM_PAIRS = 850;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 40;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [127:0] s_tdata  = '0;
    logic         m_tready = 1'b0;

    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [55:0] m_tdata;
    wire logic [0:0]  m_tuser;

    int mismatch_count;
    int pending_count;
    int result_count;
    int flagged_count;
    int clipped_count;
    int pairs_sent    = 0;
    int directed_sent = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    euclidean_distance_wilkes_sqrt_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    distance_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .flagged_count  (flagged_count),
        .clipped_count  (clipped_count)
    );

    // Back to back when steady; otherwise mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int idle_cycles(input bit steady);
        int pick;
        if (steady) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer(input logic [127:0] word, input bit steady);
        int gap;
        gap = idle_cycles(steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pairs_sent++;
        @(negedge aclk);
    endtask

    task automatic send_pair(input logic [15:0] x0, input logic [15:0] x1,
                             input logic [15:0] x2, input logic [15:0] x3,
                             input logic [15:0] y0, input logic [15:0] y1,
                             input logic [15:0] y2, input logic [15:0] y3);
        offer({y3, y2, y1, y0, x3, x2, x1, x0}, 1'b0);
        directed_sent++;
    endtask

    function automatic logic [127:0] random_pair();
        logic [127:0] word;
        logic [15:0]  xv;
        logic [15:0]  yv;
        int           kind;
        int           near;
        int           i;
        kind = $urandom_range(0, 9);
        for (i = 0; i < 4; i++) begin
            case (kind)
                0, 1, 2, 3, 4, 5: begin
                    xv = 16'($urandom_range(0, 32768));
                    yv = 16'($urandom_range(0, 32768));
                end
                6: begin
                    // Nearly equal vectors give tiny distances.
                    xv   = 16'($urandom_range(0, 32768));
                    near = int'(xv) + int'($urandom_range(0, 64)) - 32;
                    if (near < 0) begin
                        near = 0;
                    end
                    if (near > 32768) begin
                        near = 32768;
                    end
                    yv = near[15:0];
                end
                7: begin
                    xv = 16'($urandom_range(0, 65535));
                    yv = 16'($urandom_range(0, 65535));
                end
                8: begin
                    // Large differences land the sum around the divergence limit.
                    xv = 16'($urandom_range(20000, 32768));
                    yv = 16'($urandom_range(0, 6000));
                end
                default: begin
                    xv = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
                    yv = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                word[16*i +: 16]      = xv;
                word[64 + 16*i +: 16] = yv;
            end else begin
                word[16*i +: 16]      = yv;
                word[64 + 16*i +: 16] = xv;
            end
        end
        return word;
    endfunction

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: ready runs and stalls of random length, plus one long hold-off
    // while the sender keeps offering, so the pipeline fills and stalls its input.
    initial begin
        int run_len;
        int stall_len;
        int pass;
        pass = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            pass++;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run_len) @(negedge aclk);
            if (pass == 40) begin
                stall_len = LONG_HOLD;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_len = $urandom_range(10, 50);
            end else begin
                stall_len = $urandom_range(1, 3);
            end
            m_tready <= 1'b0;
            repeat (stall_len) @(negedge aclk);
        end
    end

    initial begin
        int  i;
        bit  steady;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd32768, 16'd32768, 16'd32768, 16'd32768,
                  16'd32768, 16'd32768, 16'd32768, 16'd32768);
        send_pair(16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd0, 16'd0);
        send_pair(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd8192, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd23170, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd16384, 16'd16384, 16'd16384, 16'd16384,
                  16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd32768, 16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd32768, 16'd32768, 16'd23170, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        // Just below the divergence limit, then exactly on it.
        send_pair(16'd32768, 16'd32768, 16'd32767, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd32768, 16'd32768, 16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd32768, 16'd32768, 16'd32768, 16'd32768,
                  16'd0, 16'd0, 16'd0, 16'd0);
        // Elements above 1.0, up to a squared distance that overflows 33 bits.
        send_pair(16'd40000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                  16'h5555, 16'h5555, 16'h5555, 16'h5555);
        send_pair(16'h5555, 16'h5555, 16'h5555, 16'h5555,
                  16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA);

        steady = 1'b0;
        for (i = 0; i < RANDOM_PAIRS; i++) begin
            // Now and then a stretch of back-to-back transactions.
            if (i % 50 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            offer(random_pair(), steady);
        end
        s_tvalid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Summary: %0d vector pairs sent (%0d directed), %0d results checked.",
                 pairs_sent, directed_sent, result_count);
        $display("Summary: %0d at or past the divergence limit, %0d with a clipped sum.",
                 flagged_count, clipped_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
